>>> rtl/wot_pkg.sv
// ----------------------------------------------------------------------------
// wot_pkg: shared types and constants of the word occurrence table
// Holds the request and response item types, the sequencer states and the
// punctuation test used at the end of a word.
// ----------------------------------------------------------------------------
package wot_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_LEN_DEF     = 32;

   // Command codes of a request item.
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Kind codes of a response item.
   localparam logic KIND_WORD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] char_byte;
      logic       last_char;
      logic [9:0] read_index;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  slot;
      logic [31:0] occurrences;
      logic        is_new;
      logic        table_full;
      logic        word_truncated;
      logic [7:0]  out_char;
      logic        char_valid;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIM,
      ST_LEN_RD,
      ST_LEN_CHK,
      ST_CMP_CHK,
      ST_HIT_WR,
      ST_INS,
      ST_COPY,
      ST_RD_LEN,
      ST_RD_CHK,
      ST_RD_CHR
   } state_type;

   // ASCII punctuation: 33-47, 58-64, 91-96, 123-126.
   function automatic logic is_punct(input logic [7:0] c);
      is_punct = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                 (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
   endfunction

endpackage

>>> rtl/wot_ram.sv
// ----------------------------------------------------------------------------
// wot_ram: generic single-port RAM
// One access a cycle, a write also reading the old word; read data is registered.
// ----------------------------------------------------------------------------
module wot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

>>> rtl/word_occurrence_table.sv
// ----------------------------------------------------------------------------
// word_occurrence_table: counts distinct words in insertion order
// Word characters are buffered; at the end of a word the table is scanned.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one item per character of a word (last_char marks
//   the final one) or a read command. The rsp_ channel returns one item per
//   finished word, or one item per character of a read entry.
//   A character that does not end a word is taken and gives nothing; the next
//   character can follow in the next cycle. A word end is taken, then the word
//   is trimmed when the buffer was full, then the scan starts; per used entry
//   the length is checked and, on a length match, the characters are compared
//   one by one. A hit then updates the count; a miss copies the word into a new
//   entry, or gives a table-full item when the table is full. The item is valid
//   in the cycle after the count update, the last copy step or the full check.
//   A read of a used entry fetches length and count, then gives one character
//   item a cycle (at most 32) while the receiver takes them, or one item if the
//   entry is empty; an unused entry gives its item in the cycle after it is taken.
//   The block takes no request while an item is at work or a response waits.
//   If the receiver stalls, the response register holds and the block waits.
//   Reset clears the word in progress and empties the table; no clearing pass
//   is needed, as entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module word_occurrence_table
   import wot_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_LEN     = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int EW   = $clog2(TABLE_DEPTH);
   localparam int CW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int UW   = $clog2(TABLE_DEPTH + 1);
   localparam int WAW  = EW + CW;
   localparam int RMAX = (MAX_LEN < 32) ? MAX_LEN : 32;

   state_type state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic trunc_ff, trunc_in;
   logic [UW-1:0] used_ff, used_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;

   // Memory ports.
   logic wb_we; logic [CW-1:0] wb_a; logic [7:0] wb_wd, wb_rd;
   logic tw_we; logic [WAW-1:0] tw_a; logic [7:0] tw_wd, tw_rd;
   logic tl_we; logic [EW-1:0] tl_a; logic [LW-1:0] tl_wd, tl_rd;
   logic tc_we; logic [EW-1:0] tc_a; logic [31:0] tc_wd, tc_rd;

   wot_ram #(.WIDTH(8), .DEPTH(1 << CW)) u_buf (
      .clock, .wr_en(wb_we), .addr(wb_a), .wr_data(wb_wd), .rd_data(wb_rd));
   wot_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * (1 << CW))) u_words (
      .clock, .wr_en(tw_we), .addr(tw_a), .wr_data(tw_wd), .rd_data(tw_rd));
   wot_ram #(.WIDTH(LW), .DEPTH(TABLE_DEPTH)) u_lens (
      .clock, .wr_en(tl_we), .addr(tl_a), .wr_data(tl_wd), .rd_data(tl_rd));
   wot_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_counts (
      .clock, .wr_en(tc_we), .addr(tc_a), .wr_data(tc_wd), .rd_data(tc_rd));

   assign req_stall = (state_ff != ST_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         trunc_ff <= 1'b0;
         used_ff  <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         trunc_ff <= trunc_in;
         used_ff  <= used_in;
         rspv_ff  <= rspv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      idx_ff  <= idx_in;
      rlen_ff <= rlen_in;
      rsp_ff  <= rsp_in;
   end

   // Sequencer: buffering, table scan, insert and readout.
   always_comb begin
      logic [UW-1:0] ent_ext;
      logic [LW-1:0] idx_nx;
      logic          rsp_free;
      state_in = state_ff;
      len_in   = len_ff;
      trunc_in = trunc_ff;
      used_in  = used_ff;
      ent_in   = ent_ff;
      idx_in   = idx_ff;
      rlen_in  = rlen_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && rsp_stall;
      wb_we = 1'b0; wb_a = idx_ff[CW-1:0]; wb_wd = req_data.char_byte;
      tw_we = 1'b0; tw_a = {ent_ff, idx_ff[CW-1:0]}; tw_wd = wb_rd;
      tl_we = 1'b0; tl_a = ent_ff; tl_wd = len_ff;
      tc_we = 1'b0; tc_a = ent_ff; tc_wd = 32'd1;
      ent_ext  = UW'(ent_ff);
      idx_nx   = idx_ff + LW'(1);
      rsp_free = !rspv_ff || !rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !rspv_ff) begin
               if (req_data.command == CMD_READ) begin
                  rsp_in = '0;
                  rsp_in.kind = KIND_READ;
                  rsp_in.slot = req_data.read_index;
                  rsp_in.last_result = 1'b1;
                  idx_in = '0;
                  if (32'(req_data.read_index) >= 32'(used_ff)) begin
                     rspv_in = 1'b1;
                  end else begin
                     ent_in = EW'(req_data.read_index);
                     state_in = ST_RD_LEN;
                  end
               end else begin
                  // Store the character if there is room, else flag truncation;
                  // a stored trailing punctuation mark is not counted.
                  if (len_ff < LW'(MAX_LEN)) begin
                     wb_we = 1'b1;
                     wb_a = len_ff[CW-1:0];
                     len_in = len_ff + LW'(1);
                     if (req_data.last_char && is_punct(req_data.char_byte)) begin
                        len_in = len_ff;
                     end
                  end else begin
                     trunc_in = 1'b1;
                     wb_a = CW'(MAX_LEN - 1);
                  end
                  if (req_data.last_char) begin
                     ent_in = '0;
                     state_in = (len_ff < LW'(MAX_LEN)) ? ST_LEN_RD : ST_TRIM;
                  end
               end
            end
         end
         ST_TRIM: begin
            // Buffer full: the last stored character was read; trim it if punctuation.
            if (is_punct(wb_rd)) begin
               len_in = len_ff - LW'(1);
            end
            state_in = ST_LEN_RD;
         end
         ST_LEN_RD: begin
            idx_in = '0;
            if (used_ff == '0) begin
               state_in = ST_INS;
            end else begin
               state_in = ST_LEN_CHK;
            end
         end
         ST_LEN_CHK: begin
            // Length compare of the current entry.
            idx_in = '0;
            if (tl_rd == len_ff) begin
               if (len_ff == '0) begin
                  state_in = ST_HIT_WR;
               end else begin
                  wb_a = '0;
                  tw_a = {ent_ff, {CW{1'b0}}};
                  state_in = ST_CMP_CHK;
               end
            end else if (ent_ext + UW'(1) >= used_ff) begin
               state_in = ST_INS;
            end else begin
               ent_in = ent_ff + EW'(1);
               tl_a = ent_in;
            end
         end
         ST_CMP_CHK: begin
            // One character compared a cycle; the next pair is fetched.
            wb_a = idx_nx[CW-1:0];
            tw_a = {ent_ff, idx_nx[CW-1:0]};
            if (wb_rd != tw_rd) begin
               idx_in = '0;
               if (ent_ext + UW'(1) >= used_ff) begin
                  state_in = ST_INS;
               end else begin
                  ent_in = ent_ff + EW'(1);
                  tl_a = ent_in;
                  state_in = ST_LEN_CHK;
               end
            end else if (idx_nx == len_ff) begin
               state_in = ST_HIT_WR;
            end else begin
               idx_in = idx_nx;
            end
         end
         ST_HIT_WR: begin
            // Count read data is valid now; saturating increment.
            tc_we = 1'b1;
            tc_wd = (tc_rd == '1) ? tc_rd : tc_rd + 32'd1;
            rsp_in = '0;
            rsp_in.kind = KIND_WORD;
            rsp_in.slot = 10'(ent_ff);
            rsp_in.occurrences = tc_wd;
            rsp_in.word_truncated = trunc_ff;
            rsp_in.last_result = 1'b1;
            rspv_in = 1'b1;
            len_in = '0; trunc_in = 1'b0;
            state_in = ST_IDLE;
         end
         ST_INS: begin
            // No match: append the word unless the table is full.
            if (used_ff >= UW'(TABLE_DEPTH)) begin
               rsp_in = '0;
               rsp_in.kind = KIND_WORD;
               rsp_in.table_full = 1'b1;
               rsp_in.word_truncated = trunc_ff;
               rsp_in.last_result = 1'b1;
               rspv_in = 1'b1;
               len_in = '0; trunc_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               ent_in = EW'(used_ff);
               wb_a = '0;
               idx_in = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            // Copy loop: buffer data at idx_ff is on wb_rd.
            if (idx_ff == len_ff) begin
               tl_we = 1'b1;
               tc_we = 1'b1;
               used_in = used_ff + UW'(1);
               rsp_in = '0;
               rsp_in.kind = KIND_WORD;
               rsp_in.slot = 10'(ent_ff);
               rsp_in.occurrences = 32'd1;
               rsp_in.is_new = 1'b1;
               rsp_in.word_truncated = trunc_ff;
               rsp_in.last_result = 1'b1;
               rspv_in = 1'b1;
               len_in = '0; trunc_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               tw_we = 1'b1;
               idx_in = idx_nx;
               wb_a = idx_nx[CW-1:0];
            end
         end
         ST_RD_LEN: begin
            // Length, count and first character are fetched.
            state_in = ST_RD_CHK;
         end
         ST_RD_CHK: begin
            rsp_in.occurrences = tc_rd;
            if (tl_rd == '0) begin
               rspv_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rlen_in = (tl_rd > LW'(RMAX)) ? LW'(RMAX) : tl_rd;
               state_in = ST_RD_CHR;
            end
         end
         ST_RD_CHR: begin
            // One character item a cycle while the response register frees.
            if (rsp_free) begin
               rsp_in.out_char = tw_rd;
               rsp_in.char_valid = 1'b1;
               rsp_in.last_result = (idx_nx == rlen_ff);
               rspv_in = 1'b1;
               idx_in = idx_nx;
               tw_a = {ent_ff, idx_nx[CW-1:0]};
               if (idx_nx == rlen_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
